>>> design/fba_pkg.sv
// Package for the fixed block allocator: field widths, status and request codes,
// and the link store access type shared by the sequencer and the link RAM.
// No dependencies.
package fba_pkg;

   // Width of a block index on the ports and in the link store.
   localparam int IDX_W = 6;
   localparam int STATUS_W = 2;

   // Default pool size.
   localparam int DEFAULT_NUM_BLOCKS = 64;

   // Request kinds.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FREED = 2'd2;

   // One access to the single-port link store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] wr_data;
   } link_req_type;

   // A finished result handed from the sequencer to the output register.
   typedef struct packed {
      logic post;
      logic [IDX_W-1:0] block_index;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

>>> design/fba_req_if.sv
// Request channel of the fixed block allocator: valid/ready plus one item.
// Depends on fba_pkg.
interface fba_req_if import fba_pkg::*; ();
   logic valid;
   logic ready;
   logic kind;
   logic [IDX_W-1:0] free_index;

   modport source (output valid, output kind, output free_index, input ready);
   modport sink (input valid, input kind, input free_index, output ready);
endinterface

>>> design/fba_rsp_if.sv
// Response channel of the fixed block allocator: valid/ready plus one item.
// Depends on fba_pkg.
interface fba_rsp_if import fba_pkg::*; ();
   logic valid;
   logic ready;
   logic [IDX_W-1:0] block_index;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output block_index, output status, input ready);
   modport sink (input valid, input block_index, input status, output ready);
endinterface

>>> design/fba_link_ram.sv
// Single-port link store of the free list: one access per cycle, registered read data.
// Depends on fba_pkg.
module fba_link_ram import fba_pkg::*; #(
   parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS
) (
   input logic clock,
   input link_req_type link_req,
   output logic [IDX_W-1:0] rd_data
);

   // Only blocks that a free can name ever get a link.
   localparam int LINK_DEPTH = (NUM_BLOCKS < (1 << IDX_W)) ? NUM_BLOCKS : (1 << IDX_W);
   localparam int LAW = $clog2(LINK_DEPTH);

   logic [IDX_W-1:0] link_mem_ff [LINK_DEPTH];
   logic [IDX_W-1:0] rd_data_ff;
   logic [LAW-1:0] addr;

   assign addr = link_req.addr[LAW-1:0];

   // Write port.
   always_ff @(posedge clock) begin
      if (link_req.wr_en) begin
         link_mem_ff[addr] <= link_req.wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (link_req.rd_en) begin
         rd_data_ff <= link_mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/fba_ctrl.sv
// Sequencer of the fixed block allocator: bump counter, list head and the steps
// that walk the link store through its single port. Depends on fba_pkg and fba_req_if.
module fba_ctrl import fba_pkg::*; #(
   parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS
) (
   input logic clock,
   input logic reset,
   fba_req_if.sink req_ch,
   input logic out_free,
   input logic [IDX_W-1:0] rd_data,
   output link_req_type link_req,
   output result_type result
);

   localparam int CW = $clog2(NUM_BLOCKS + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_ALLOC_LINK = 3'd2;
   localparam logic [2:0] S_ALLOC_DONE = 3'd3;
   localparam logic [2:0] S_FREE_LINK = 3'd4;
   localparam logic [2:0] S_FREE_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic list_valid_ff, list_valid_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic kind_ff, kind_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] next_ff, next_in;

   logic fresh_avail;
   logic idx_ok;
   logic [CW+IDX_W-1:0] fresh_ext;
   logic [IDX_W-1:0] fresh_idx;

   assign fresh_avail = (32'(fresh_ff) < NUM_BLOCKS);
   assign idx_ok = (32'(idx_ff) < NUM_BLOCKS);
   assign fresh_ext = {{IDX_W{1'b0}}, fresh_ff};
   assign fresh_idx = fresh_ext[IDX_W-1:0];

   assign req_ch.ready = (state_ff == S_IDLE);

   // Next-state logic: one link store access per step.
   always_comb begin
      state_in = state_ff;
      fresh_in = fresh_ff;
      list_valid_in = list_valid_ff;
      head_in = head_ff;
      kind_in = kind_ff;
      idx_in = idx_ff;
      next_in = next_ff;
      link_req = '0;
      result = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in = req_ch.kind;
               idx_in = req_ch.free_index;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (kind_ff == KIND_ALLOC) begin
               if (fresh_avail) begin
                  // Hand out the next never-used block.
                  if (out_free) begin
                     result.post = 1'b1;
                     result.block_index = fresh_idx;
                     result.status = ST_ALLOCATED;
                     fresh_in = fresh_ff + CW'(1);
                     state_in = S_IDLE;
                  end
               end else if (!list_valid_ff) begin
                  if (out_free) begin
                     result.post = 1'b1;
                     result.status = ST_FULL;
                     state_in = S_IDLE;
                  end
               end else begin
                  // Fetch the entry after the head.
                  link_req.rd_en = 1'b1;
                  link_req.addr = head_ff;
                  state_in = S_ALLOC_LINK;
               end
            end else begin
               if (!idx_ok) begin
                  if (out_free) begin
                     result.post = 1'b1;
                     result.status = ST_FREED;
                     state_in = S_IDLE;
                  end
               end else if (!list_valid_ff) begin
                  // First block on an empty list links to itself.
                  if (out_free) begin
                     link_req.wr_en = 1'b1;
                     link_req.addr = idx_ff;
                     link_req.wr_data = idx_ff;
                     head_in = idx_ff;
                     list_valid_in = 1'b1;
                     result.post = 1'b1;
                     result.status = ST_FREED;
                     state_in = S_IDLE;
                  end
               end else begin
                  link_req.rd_en = 1'b1;
                  link_req.addr = head_ff;
                  state_in = S_FREE_LINK;
               end
            end
         end
         S_ALLOC_LINK: begin
            // The read data is the block to hand out; fetch its successor.
            next_in = rd_data;
            link_req.rd_en = 1'b1;
            link_req.addr = rd_data;
            state_in = S_ALLOC_DONE;
         end
         S_ALLOC_DONE: begin
            if (out_free) begin
               if (next_ff == head_ff) begin
                  list_valid_in = 1'b0;
               end else begin
                  link_req.wr_en = 1'b1;
                  link_req.addr = head_ff;
                  link_req.wr_data = rd_data;
               end
               result.post = 1'b1;
               result.block_index = next_ff;
               result.status = ST_ALLOCATED;
               state_in = S_IDLE;
            end
         end
         S_FREE_LINK: begin
            // The freed block takes over the head's old successor.
            link_req.wr_en = 1'b1;
            link_req.addr = idx_ff;
            link_req.wr_data = rd_data;
            state_in = S_FREE_DONE;
         end
         S_FREE_DONE: begin
            if (out_free) begin
               link_req.wr_en = 1'b1;
               link_req.addr = head_ff;
               link_req.wr_data = idx_ff;
               result.post = 1'b1;
               result.status = ST_FREED;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fresh_ff <= '0;
         list_valid_ff <= 1'b0;
         head_ff <= '0;
      end else begin
         state_ff <= state_in;
         fresh_ff <= fresh_in;
         list_valid_ff <= list_valid_in;
         head_ff <= head_in;
      end
   end

   // Item payload.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      idx_ff <= idx_in;
      next_ff <= next_in;
   end

endmodule

>>> design/fixed_block_allocator_top.sv
// Fixed block allocator top level: sequencer, link RAM and the response register.
// A bump allocation, a full pool or a free into an empty list finishes in S_EXEC; an allocation
// from a non-empty list also passes S_ALLOC_LINK and S_ALLOC_DONE, a free into one S_FREE_LINK
// and S_FREE_DONE. A new item is accepted only in S_IDLE, after the last result has posted.
// Reset clears the bump counter, the list head and flag, and the response valid;
// the link RAM is not cleared, as every link is written before it is read.
// Depends on fba_pkg, fba_req_if, fba_rsp_if, fba_link_ram and fba_ctrl.
module fixed_block_allocator_top import fba_pkg::*; #(
   parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS
) (
   input logic clock,
   input logic reset,
   fba_req_if.sink req_ch,
   fba_rsp_if.source rsp_ch
);

   link_req_type link_req;
   result_type result;
   logic [IDX_W-1:0] rd_data;
   logic out_free;

   logic rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_index_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   fba_ctrl #(.NUM_BLOCKS(NUM_BLOCKS)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .out_free(out_free),
      .rd_data(rd_data),
      .link_req(link_req),
      .result(result)
   );

   fba_link_ram #(.NUM_BLOCKS(NUM_BLOCKS)) u_link_ram (
      .clock(clock),
      .link_req(link_req),
      .rd_data(rd_data)
   );

   // The response register may take a new item when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in = result.post || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.post) begin
         rsp_index_ff <= result.block_index;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.block_index = rsp_index_ff;
   assign rsp_ch.status = rsp_status_ff;

   // A result is only produced when the response register can take it.
   a_post_when_free: assert property (@(posedge clock) disable iff (reset)
      result.post |-> out_free)
      else $error("result posted while the response register is occupied");

   // The sequencer is busy in the cycle after it accepts an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while an item is still in progress");

   // The link RAM port is never asked to read and write at once.
   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(link_req.rd_en && link_req.wr_en))
      else $error("link RAM read and write in the same cycle");

   // Only an allocation carries a nonzero block index.
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_ALLOCATED)) |-> (rsp_index_ff == '0))
      else $error("nonzero block index on a full or free response");

endmodule
